/* rtl/core/sorted_key_table_macros.svh */
// ---------------------------------------------------------------------------
// sorted key table assertion macros
// Concurrent check wrappers used by the table's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SKT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_key_table check failed");

// consequent must hold in the cycle after the antecedent
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_key_table check failed");

`endif

/* rtl/core/skt_pkg.sv */
// ---------------------------------------------------------------------------
// sorted key table package
// Field widths, command and state codes, and control bundles.
// ---------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 5;
    localparam int IDX_OUT_W = 5;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LINEAR = 2'd2,
        CMD_BINARY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_SEARCH = 2'd2,
        ST_DONE   = 2'd3
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                    insert_en;
        logic                    remove_en;
        logic                    capture_en;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // search unit control and status
    typedef struct packed {
        logic start;
        logic linear;
    } t_search_ctl;

    typedef struct packed {
        logic done;
        logic found;
    } t_search_stat;

endpackage

/* rtl/core/skt_ifs.sv */
// ---------------------------------------------------------------------------
// sorted key table channels
// Command and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface skt_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [skt_pkg::CMD_W-1:0]       command;
    logic signed [skt_pkg::KEY_W-1:0] key;
    logic signed [skt_pkg::POS_W-1:0] position;

    modport source (output valid, output command, output key, output position, input ready);
    modport sink (input valid, input command, input key, input position, output ready);
endinterface

interface skt_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 success;
    logic signed [skt_pkg::IDX_OUT_W-1:0] found_index;
    logic [skt_pkg::CNT_OUT_W-1:0]        entry_count;

    modport source (output valid, output success, output found_index, output entry_count,
                    input ready);
    modport sink (input valid, input success, input found_index, input entry_count,
                  output ready);
endinterface

/* rtl/core/skt_cell.sv */
// ---------------------------------------------------------------------------
// sorted key table cell
// One table entry: compares against the broadcast key, shifts up on insert,
// shifts down on remove, and captures its compare flags for a search.
// ---------------------------------------------------------------------------
module skt_cell (
    input  logic                             i_clk,
    input  skt_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_valid,
    input  logic                             i_shift_down,
    input  logic signed [skt_pkg::KEY_W-1:0] i_left_key,
    input  logic                             i_left_lt,
    input  logic signed [skt_pkg::KEY_W-1:0] i_right_key,
    output logic signed [skt_pkg::KEY_W-1:0] o_key,
    output logic                             o_lt_now,
    output logic                             o_lt,
    output logic                             o_eq
);

    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic                             r_lt;
    logic                             r_eq;
    logic                             lt_now;
    logic                             eq_now;

    // compare held entry with the broadcast key
    always_comb begin
        lt_now = i_valid && (r_key < i_ctl.key);
        eq_now = i_valid && (r_key == i_ctl.key);
    end

    // entry update: insert shifts up, remove shifts down
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert_en && !lt_now) begin
            r_key <= i_left_lt ? i_ctl.key : i_left_key;
        end else if (i_ctl.remove_en && i_shift_down) begin
            r_key <= i_right_key;
        end
    end

    // flags for the search unit
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture_en) begin
            r_lt <= lt_now;
            r_eq <= eq_now;
        end
    end

    assign o_key    = r_key;
    assign o_lt_now = lt_now;
    assign o_lt     = r_lt;
    assign o_eq     = r_eq;

endmodule

/* rtl/core/skt_search.sv */
// ---------------------------------------------------------------------------
// sorted key table search unit
// Bisects over the captured compare flags, one probe per cycle. Linear mode
// finds the first equal entry, binary mode stops at the first probe hit.
// ---------------------------------------------------------------------------
module skt_search #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  skt_pkg::t_search_ctl         i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  logic [CAPACITY-1:0]          i_lt,
    input  logic [CAPACITY-1:0]          i_eq,
    output skt_pkg::t_search_stat        o_stat,
    output logic [$clog2(CAPACITY)-1:0]  o_index
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam logic signed [CW:0] ONE = 1;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_linear;
    logic                 r_found;
    logic [IW-1:0]        r_idx;
    logic signed [CW:0]   r_lo;
    logic signed [CW:0]   r_hi;
    logic [CW:0]          sum;
    logic [CW-1:0]        mid;
    logic signed [CW:0]   mid_s;
    logic                 in_range;
    logic                 probe_lt;
    logic                 probe_eq;

    // midpoint probe
    always_comb begin
        in_range = (r_lo <= r_hi);
        sum      = {1'b0, r_lo[CW-1:0]} + {1'b0, r_hi[CW-1:0]};
        mid      = sum[CW:1];
        mid_s    = $signed({1'b0, mid});
        probe_lt = i_lt[mid[IW-1:0]];
        probe_eq = i_eq[mid[IW-1:0]];
    end

    // control of the probe loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!in_range || (!r_linear && !probe_lt && probe_eq)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // bounds and result
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_linear <= i_ctl.linear;
            r_found  <= 1'b0;
            r_lo     <= '0;
            r_hi     <= $signed({1'b0, i_count}) - ONE;
        end else if (r_busy && in_range) begin
            if (probe_lt) begin
                r_lo <= mid_s + ONE;
            end else if (probe_eq) begin
                r_found <= 1'b1;
                r_idx   <= mid[IW-1:0];
                r_hi    <= mid_s - ONE;
            end else begin
                r_hi <= mid_s - ONE;
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_index      = r_idx;

endmodule

/* rtl/core/sorted_key_table.sv */
// ---------------------------------------------------------------------------
// sorted key table
// Ascending table of signed keys with insert, remove, linear and binary search.
// ---------------------------------------------------------------------------
// The table is a row of CAPACITY cells, one key each. Insert and remove update
// every cell at once (each cell takes its own, its left or its right
// neighbor's value; insert picks by comparing with the request key, remove by
// the request position). A search first latches every cell's compare flags,
// then the search unit bisects over them at one probe per cycle until the
// range is empty, and a binary hit ends the loop early. One request is worked
// at a time; a finished response sits in an output register so the next
// request is taken while it waits. Entries above the count hold stale keys
// and are never reported; there is no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
    parameter int CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    skt_cmd_if.sink      i_cmd,
    skt_rsp_if.source    o_rsp
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int XW = CW + skt_pkg::POS_W;

    skt_pkg::t_state                  r_state;
    skt_pkg::t_state                  n_state;
    skt_pkg::t_cmd                    r_cmd;
    logic signed [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::POS_W-1:0]        r_pos;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic                             r_ok;
    logic [IW-1:0]                    r_idx;
    logic                             r_out_valid;
    logic                             r_success;
    logic [skt_pkg::IDX_OUT_W-1:0]    r_found_index;
    logic [skt_pkg::CNT_OUT_W-1:0]    r_entry_count;

    logic                  accept;
    logic                  exec;
    logic                  is_search;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  load_out;
    skt_pkg::t_cell_ctl    cell_ctl;
    skt_pkg::t_search_ctl  srch_ctl;
    skt_pkg::t_search_stat srch_stat;
    logic [IW-1:0]         srch_index;
    logic [IW+4:0]         idx_ext;
    logic [CW+4:0]         count_ext;

    logic signed [skt_pkg::KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]              cell_lt_now;
    logic [CAPACITY-1:0]              flag_lt;
    logic [CAPACITY-1:0]              flag_eq;
    logic [CAPACITY-1:0]              lane_valid;
    logic [CAPACITY-1:0]              lane_shift;

    // request decode and control outputs
    always_comb begin
        accept    = i_cmd.valid && (r_state == skt_pkg::ST_IDLE);
        exec      = (r_state == skt_pkg::ST_EXEC);
        is_search = (r_cmd == skt_pkg::CMD_LINEAR) || (r_cmd == skt_pkg::CMD_BINARY);
        ins_ok    = (r_count < CW'(CAPACITY));
        rem_ok    = !r_pos[skt_pkg::POS_W-1]
                    && ({{CW{1'b0}}, r_pos} < {{skt_pkg::POS_W{1'b0}}, r_count});
        load_out  = (r_state == skt_pkg::ST_DONE) && (!r_out_valid || o_rsp.ready);

        cell_ctl.insert_en  = exec && (r_cmd == skt_pkg::CMD_INSERT) && ins_ok;
        cell_ctl.remove_en  = exec && (r_cmd == skt_pkg::CMD_REMOVE) && rem_ok;
        cell_ctl.capture_en = exec && is_search;
        cell_ctl.key        = r_key;

        srch_ctl.start  = exec && is_search;
        srch_ctl.linear = (r_cmd == skt_pkg::CMD_LINEAR);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skt_pkg::ST_IDLE: begin
                if (accept) n_state = skt_pkg::ST_EXEC;
            end
            skt_pkg::ST_EXEC: begin
                n_state = is_search ? skt_pkg::ST_SEARCH : skt_pkg::ST_DONE;
            end
            skt_pkg::ST_SEARCH: begin
                if (srch_stat.done) n_state = skt_pkg::ST_DONE;
            end
            skt_pkg::ST_DONE: begin
                if (load_out) n_state = skt_pkg::ST_IDLE;
            end
            default: n_state = skt_pkg::ST_IDLE;
        endcase
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (cell_ctl.insert_en) begin
            n_count = r_count + CW'(1);
        end else if (cell_ctl.remove_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= skt_pkg::t_cmd'(i_cmd.command);
            r_key <= i_cmd.key;
            r_pos <= i_cmd.position;
        end
    end

    // outcome of the current request
    always_ff @(posedge i_clk) begin
        if (exec && !is_search) begin
            r_ok <= (r_cmd == skt_pkg::CMD_INSERT) ? ins_ok : rem_ok;
        end else if (srch_stat.done) begin
            r_ok  <= srch_stat.found;
            r_idx <= srch_index;
        end
    end

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [skt_pkg::KEY_W-1:0] left_key;
        logic                             left_lt;
        logic signed [skt_pkg::KEY_W-1:0] right_key;

        assign lane_valid[i] = (CW'(i) < r_count);
        assign lane_shift[i] = (XW'(i) >= {{CW{1'b0}}, r_pos});

        if (i == 0) begin : g_first
            assign left_key = r_key;
            assign left_lt  = 1'b1;
        end else begin : g_inner
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_lt_now[i-1];
        end

        if (i == CAPACITY-1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_body
            assign right_key = cell_key[i+1];
        end

        skt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_valid      (lane_valid[i]),
            .i_shift_down (lane_shift[i]),
            .i_left_key   (left_key),
            .i_left_lt    (left_lt),
            .i_right_key  (right_key),
            .o_key        (cell_key[i]),
            .o_lt_now     (cell_lt_now[i]),
            .o_lt         (flag_lt[i]),
            .o_eq         (flag_eq[i])
        );
    end

    // bisection over the captured flags
    skt_search #(
        .CAPACITY (CAPACITY)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (srch_ctl),
        .i_count (r_count),
        .i_lt    (flag_lt),
        .i_eq    (flag_eq),
        .o_stat  (srch_stat),
        .o_index (srch_index)
    );

    // response register
    assign idx_ext   = {5'b0, r_idx};
    assign count_ext = {5'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_success     <= r_ok;
            r_found_index <= (is_search && r_ok) ? idx_ext[4:0] : '1;
            r_entry_count <= count_ext[4:0];
        end
    end

    assign i_cmd.ready       = (r_state == skt_pkg::ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.success     = r_success;
    assign o_rsp.found_index = r_found_index;
    assign o_rsp.entry_count = r_entry_count;

    // checks
    `SKT_ASSERT_NEXT(a_insert_counts, i_clk, i_rst_n, cell_ctl.insert_en, r_count == $past(r_count) + CW'(1))
    `SKT_ASSERT_NEXT(a_search_keeps_count, i_clk, i_rst_n, srch_ctl.start, $stable(r_count))
    `SKT_ASSERT_NOW(a_done_in_search, i_clk, i_rst_n, srch_stat.done, r_state == skt_pkg::ST_SEARCH)

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted key table regression bench
// Drives insert, remove and both search requests into the table, mirrors the
// ascending key store in a local predictor and checks every response field.
// Directed requests cover the empty table, key extremes and the full table;
// random phases then fill and drain the table under varied handshake idling.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY = 16;
    localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [skt_pkg::IDX_OUT_W-1:0] NO_INDEX = '1;
    localparam int MAX_REPORTED = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [skt_pkg::IDX_OUT_W-1:0] t_index;
    typedef logic [skt_pkg::CNT_OUT_W-1:0]        t_count;
    typedef logic signed [skt_pkg::POS_W-1:0]     t_pos;

    // one response as the table should give it
    typedef struct {
        logic   success;
        t_index found_index;
        t_count entry_count;
    } t_table_result;

    logic i_clk;
    logic i_rst_n;

    skt_cmd_if cmd_ch();
    skt_rsp_if rsp_ch();

    sorted_key_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    // predicted table contents
    logic signed [skt_pkg::KEY_W-1:0] key_store [CAPACITY];
    int                               stored_count;

    t_table_result pending_results [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int requests_sent;
    int full_rejects;
    int position_rejects;
    int search_hits;
    int search_misses;
    int peak_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", pending_results.size());
        $display("sorted_key_table regression: fail");
        $finish;
    end

    // receiver ready, random stalls after reset
    always @(negedge i_clk) begin
        rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    // apply one accepted request to the predicted table
    function automatic t_table_result apply_command(
            input skt_pkg::t_cmd cmd,
            input logic signed [skt_pkg::KEY_W-1:0] req_key,
            input t_pos req_pos);
        t_table_result res;
        int at;
        int j;
        int lo;
        int hi;
        int mid;
        int pos;
        res.success     = 1'b0;
        res.found_index = NO_INDEX;
        pos = req_pos;
        case (cmd)
            skt_pkg::CMD_INSERT: begin
                if (stored_count >= CAPACITY) begin
                    full_rejects++;
                end else begin
                    at = 0;
                    while (at < stored_count && key_store[at] < req_key) at++;
                    for (j = stored_count; j > at; j--) key_store[j] = key_store[j-1];
                    key_store[at] = req_key;
                    stored_count++;
                    res.success = 1'b1;
                end
            end
            skt_pkg::CMD_REMOVE: begin
                if (pos < 0 || pos >= stored_count) begin
                    position_rejects++;
                end else begin
                    for (j = pos; j + 1 < stored_count; j++) key_store[j] = key_store[j+1];
                    stored_count--;
                    res.success = 1'b1;
                end
            end
            skt_pkg::CMD_LINEAR: begin
                // scan stops at the first entry above the key
                for (j = 0; j < stored_count && key_store[j] <= req_key; j++) begin
                    if (key_store[j] == req_key) begin
                        res.found_index = t_index'(j);
                        res.success     = 1'b1;
                        break;
                    end
                end
            end
            default: begin
                // midpoint probing, index among duplicates is whichever is hit first
                lo = 0;
                hi = stored_count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (key_store[mid] < req_key) begin
                        lo = mid + 1;
                    end else if (key_store[mid] > req_key) begin
                        hi = mid - 1;
                    end else begin
                        res.found_index = t_index'(mid);
                        res.success     = 1'b1;
                        break;
                    end
                end
            end
        endcase
        if (cmd == skt_pkg::CMD_LINEAR || cmd == skt_pkg::CMD_BINARY) begin
            if (res.success) search_hits++;
            else search_misses++;
        end
        if (stored_count > peak_count) peak_count = stored_count;
        res.entry_count = t_count'(stored_count);
        return res;
    endfunction

    // send one request, predict its response once it is taken
    task automatic send_request(input skt_pkg::t_cmd cmd,
                                input logic signed [skt_pkg::KEY_W-1:0] req_key,
                                input t_pos req_pos);
        t_table_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= cmd;
        cmd_ch.key      <= req_key;
        cmd_ch.position <= req_pos;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        res = apply_command(cmd, req_key, req_pos);
        pending_results.push_back(res);
        requests_sent++;
    endtask

    // stop sending until every response is back
    task automatic hold_until_drained();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_table_result want,
                                 input t_table_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("%0t: %s: expected success %b index %0d count %0d,",
                     $realtime, what, want.success, want.found_index, want.entry_count);
            $display("    got success %b index %0d count %0d",
                     got.success, got.found_index, got.entry_count);
        end
    endtask

    // response checker
    always @(posedge i_clk) begin : check_responses
        t_table_result want;
        t_table_result got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.success     = rsp_ch.success;
            got.found_index = rsp_ch.found_index;
            got.entry_count = rsp_ch.entry_count;
            if (pending_results.size() == 0) begin
                want.success     = 1'bx;
                want.found_index = 'x;
                want.entry_count = 'x;
                note_mismatch("response with no request outstanding", want, got);
            end else begin
                want = pending_results.pop_front();
                if (got.success !== want.success || got.found_index !== want.found_index
                        || got.entry_count !== want.entry_count) begin
                    note_mismatch("response mismatch", want, got);
                end
            end
        end
    end

    // key mix: small duplicates, stored keys, extremes, full range
    function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 35) return int'($urandom_range(6)) - 3;
        if (r < 60 && stored_count > 0) return key_store[$urandom_range(stored_count - 1)];
        if (r < 70) begin
            case ($urandom_range(3))
                0:       return KEY_MIN;
                1:       return KEY_MIN + 1;
                2:       return KEY_MAX - 1;
                default: return KEY_MAX;
            endcase
        end
        return $urandom;
    endfunction

    // random traffic that walks the table between empty and full
    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                    input bit pause_midway);
        bit filling;
        int r;
        int i;
        skt_pkg::t_cmd cmd;
        t_pos pos;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        filling = 1'b1;
        for (i = 0; i < n_items; i++) begin
            if (pause_midway && i == n_items / 2) hold_until_drained();
            if (stored_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
            if (stored_count == 0) filling = 1'b1;
            if ($urandom_range(39) == 0) filling = ~filling;
            r = $urandom_range(99);
            if (r < (filling ? 50 : 12)) cmd = skt_pkg::CMD_INSERT;
            else if (r < 62) cmd = skt_pkg::CMD_REMOVE;
            else if (r < 81) cmd = skt_pkg::CMD_LINEAR;
            else cmd = skt_pkg::CMD_BINARY;
            if (cmd == skt_pkg::CMD_REMOVE && stored_count > 0 && $urandom_range(99) < 80) begin
                pos = t_pos'($urandom_range(stored_count - 1));
            end else begin
                pos = t_pos'($urandom_range(31));
            end
            send_request(cmd, pick_key(), pos);
        end
    endtask

    // searches and removes on a table with nothing in it
    task automatic test_empty_table();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(skt_pkg::CMD_LINEAR, 0, 0);
        send_request(skt_pkg::CMD_BINARY, KEY_MIN, 0);
        send_request(skt_pkg::CMD_REMOVE, 0, 0);
    endtask

    // extreme keys, duplicates, a miss and a negative position
    task automatic test_key_extremes();
        send_request(skt_pkg::CMD_INSERT, KEY_MAX, 0);
        send_request(skt_pkg::CMD_INSERT, KEY_MIN, 0);
        send_request(skt_pkg::CMD_INSERT, 0, 0);
        send_request(skt_pkg::CMD_INSERT, 0, 0);
        send_request(skt_pkg::CMD_LINEAR, 0, 0);
        send_request(skt_pkg::CMD_BINARY, KEY_MIN, 0);
        send_request(skt_pkg::CMD_LINEAR, 7, 0);
        send_request(skt_pkg::CMD_REMOVE, 0, -1);
    endtask

    // fill to capacity, reject one more, remove the top entry
    task automatic test_capacity_limit();
        int i;
        for (i = 0; i < CAPACITY - 4; i++) begin
            send_request(skt_pkg::CMD_INSERT, int'(i % 4) - 1, 0);
        end
        send_request(skt_pkg::CMD_INSERT, KEY_MAX, 0);
        send_request(skt_pkg::CMD_REMOVE, 0, 15);
    endtask

    task automatic test_random_no_idle();
        run_random_phase(250, 0, 0, 1'b1);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(250, 69, 0, 1'b0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(250, 0, 69, 1'b0);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(250, 30, 30, 1'b0);
    endtask

    // main sequence
    initial begin
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = skt_pkg::CMD_INSERT;
        cmd_ch.key         = '0;
        cmd_ch.position    = '0;
        i_rst_n            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stored_count       = 0;
        mismatches         = 0;
        requests_sent      = 0;
        full_rejects       = 0;
        position_rejects   = 0;
        search_hits        = 0;
        search_misses      = 0;
        peak_count         = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_key_extremes();
        test_capacity_limit();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests across four idling phases, table peaked at %0d of %0d entries",
                 requests_sent, peak_count, CAPACITY);
        $display("%0d full-table inserts, %0d bad remove positions, %0d search hits, %0d misses",
                 full_rejects, position_rejects, search_hits, search_misses);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sorted_key_table regression: pass");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches,
                     pending_results.size());
            $display("sorted_key_table regression: fail");
        end
        $finish;
    end

endmodule
